>>> rtl/hla_pkg.sv
package hla_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned ENUM_WIDTH_DEF  = 8;
  localparam int unsigned THRESH_WIDTH    = 31;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned STATE_WIDTH     = 2;
  localparam int unsigned KIND_WIDTH      = 2;

  // bit positions in limit_enables
  localparam int unsigned EN_UPPER_LIMIT   = 0;
  localparam int unsigned EN_UPPER_RELEASE = 1;
  localparam int unsigned EN_LOWER_LIMIT   = 2;
  localparam int unsigned EN_LOWER_RELEASE = 3;
  localparam int unsigned EN_WIDTH         = 4;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ANALOG_MODE      = 3'd0,
    REG_LIMIT_ENABLES    = 3'd1,
    REG_UPPER_LIMIT      = 3'd2,
    REG_UPPER_RELEASE    = 3'd3,
    REG_LOWER_LIMIT      = 3'd4,
    REG_LOWER_RELEASE    = 3'd5,
    REG_CHANGE_THRESHOLD = 3'd6
  } cfg_reg_e;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_RAISE_UPPER   = 2'd0,
    KIND_RAISE_LOWER   = 2'd1,
    KIND_RELEASE_UPPER = 2'd2,
    KIND_RELEASE_LOWER = 2'd3
  } event_kind_e;

  // config data bus is at least one word so the 31-bit threshold always fits
  function automatic int unsigned cfg_data_width(int unsigned value_width);
    return (value_width > 32) ? value_width : 32;
  endfunction

endpackage

>>> rtl/hla_if.sv
interface hla_sample_if #(
  parameter int unsigned VALUE_WIDTH = hla_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned ENUM_WIDTH  = hla_pkg::ENUM_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_analog;
  logic        [ENUM_WIDTH-1:0]  sample_enum;
  logic                          force_record;

  modport source (output valid, sample_analog, sample_enum, force_record, input ready);
  modport sink   (input valid, sample_analog, sample_enum, force_record, output ready);
endinterface

interface hla_result_if;
  logic                               valid;
  logic                               ready;
  logic [hla_pkg::STATE_WIDTH-1:0]    alarm_state_out;
  logic                               alarm_event;
  logic [hla_pkg::KIND_WIDTH-1:0]     event_kind;
  logic                               record_request;

  modport source (output valid, alarm_state_out, alarm_event, event_kind, record_request,
                  input ready);
  modport sink   (input valid, alarm_state_out, alarm_event, event_kind, record_request,
                  output ready);
endinterface

interface hla_cfg_if #(
  parameter int unsigned DATA_WIDTH = hla_pkg::cfg_data_width(hla_pkg::VALUE_WIDTH_DEF)
);
  logic                                valid;
  logic                                ready;
  logic [hla_pkg::CFG_IDX_WIDTH-1:0]   index;
  logic [DATA_WIDTH-1:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/hysteresis_limit_alarm.sv
// Hysteresis limit alarm for one measured parameter.
// Pipeline: input register, then result register; the limit compares and the change
//   magnitude sit between them.
// Throughput: one sample per cycle while the result is accepted; a stalled result holds
//   only the result register and the input register keeps taking one more sample.
// Reset (async, active low): pipeline empty, unprimed, state normal, registers at defaults.
module hysteresis_limit_alarm #(
  parameter int unsigned VALUE_WIDTH = hla_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned ENUM_WIDTH  = hla_pkg::ENUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hla_sample_if.sink           sample_i,
  hla_result_if.source         result_o,
  hla_cfg_if.sink              cfg_i
);
  import hla_pkg::*;

  localparam int unsigned E10_WIDTH  = ENUM_WIDTH + 4;
  localparam int unsigned CMP_WIDTH  = (VALUE_WIDTH > E10_WIDTH) ? VALUE_WIDTH + 1
                                                                 : E10_WIDTH + 1;
  localparam int unsigned DIFF_WIDTH = VALUE_WIDTH + 1;
  localparam int unsigned MAG_WIDTH  = (DIFF_WIDTH > THRESH_WIDTH) ? DIFF_WIDTH
                                                                   : THRESH_WIDTH;

  typedef enum logic [STATE_WIDTH-1:0] {
    ST_NORMAL = 2'd0,
    ST_UPPER  = 2'd1,
    ST_LOWER  = 2'd2
  } alarm_state_e;

  // configuration
  logic                          analog_mode_q;
  logic [EN_WIDTH-1:0]           limit_en_q;
  logic signed [VALUE_WIDTH-1:0] upper_limit_q, upper_release_q;
  logic signed [VALUE_WIDTH-1:0] lower_limit_q, lower_release_q;
  logic [THRESH_WIDTH-1:0]       change_thresh_q;

  // input register
  logic                          s1_valid_q;
  logic signed [VALUE_WIDTH-1:0] s1_analog_q;
  logic [ENUM_WIDTH-1:0]         s1_enum_q;
  logic                          s1_force_q;

  // block state
  logic                          primed_q;
  logic signed [VALUE_WIDTH-1:0] prev_analog_q;
  logic [ENUM_WIDTH-1:0]         prev_enum_q;
  alarm_state_e                  state_q, state_d;

  // result register
  logic                          res_valid_q;
  alarm_state_e                  res_state_q;
  logic                          res_event_q;
  event_kind_e                   res_kind_q;
  logic                          res_record_q;

  logic advance;
  logic take_in;

  assign advance  = !res_valid_q || result_o.ready;
  assign take_in  = sample_i.valid && sample_i.ready;
  assign sample_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      analog_mode_q   <= 1'b1;
      limit_en_q      <= '0;
      upper_limit_q   <= '0;
      upper_release_q <= '0;
      lower_limit_q   <= '0;
      lower_release_q <= '0;
      change_thresh_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ANALOG_MODE:      analog_mode_q   <= cfg_i.data[0];
        REG_LIMIT_ENABLES:    limit_en_q      <= cfg_i.data[EN_WIDTH-1:0];
        REG_UPPER_LIMIT:      upper_limit_q   <= cfg_i.data[VALUE_WIDTH-1:0];
        REG_UPPER_RELEASE:    upper_release_q <= cfg_i.data[VALUE_WIDTH-1:0];
        REG_LOWER_LIMIT:      lower_limit_q   <= cfg_i.data[VALUE_WIDTH-1:0];
        REG_LOWER_RELEASE:    lower_release_q <= cfg_i.data[VALUE_WIDTH-1:0];
        REG_CHANGE_THRESHOLD: change_thresh_q <= cfg_i.data[THRESH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---- compare logic on the registered sample ----
  logic [E10_WIDTH-1:0]          enum_x10;
  logic signed [CMP_WIDTH-1:0]   cur, ul, ur, ll, lr;
  logic signed [DIFF_WIDTH-1:0]  diff;
  logic [MAG_WIDTH-1:0]          mag;
  logic                          rec, ev;
  event_kind_e                   kind;
  logic                          raise_up, raise_lo, rel_up, rel_lo;

  always_comb begin
    enum_x10 = {1'b0, s1_enum_q, 3'b000} + {3'b000, s1_enum_q, 1'b0};
    cur = analog_mode_q ? CMP_WIDTH'(s1_analog_q) : $signed(CMP_WIDTH'(enum_x10));
    ul  = CMP_WIDTH'(upper_limit_q);
    ur  = CMP_WIDTH'(upper_release_q);
    ll  = CMP_WIDTH'(lower_limit_q);
    lr  = CMP_WIDTH'(lower_release_q);

    diff = DIFF_WIDTH'(s1_analog_q) - DIFF_WIDTH'(prev_analog_q);
    mag  = diff[DIFF_WIDTH-1] ? MAG_WIDTH'(unsigned'(-diff)) : MAG_WIDTH'(unsigned'(diff));

    // analog raise is strict, enum raise includes the limit
    raise_up = limit_en_q[EN_UPPER_LIMIT] && (analog_mode_q ? (cur > ul) : (cur >= ul));
    raise_lo = limit_en_q[EN_LOWER_LIMIT] && (analog_mode_q ? (cur < ll) : (cur <= ll));
    // a disabled limit releases its alarm at once
    rel_up = !limit_en_q[EN_UPPER_LIMIT] ||
             (limit_en_q[EN_UPPER_RELEASE] ? (cur < ur) : (cur < ul));
    rel_lo = !limit_en_q[EN_LOWER_LIMIT] ||
             (limit_en_q[EN_LOWER_RELEASE] ? (cur > lr) : (cur > ll));

    rec     = 1'b1;
    ev      = 1'b0;
    kind    = KIND_RAISE_UPPER;
    state_d = ST_NORMAL;
    if (primed_q) begin
      rec = s1_force_q ||
            (analog_mode_q ? (mag > MAG_WIDTH'(change_thresh_q)) : (s1_enum_q != prev_enum_q));
      case (state_q)
        ST_UPPER: begin
          state_d = ST_UPPER;
          if (rel_up) begin
            ev = 1'b1; kind = KIND_RELEASE_UPPER; state_d = ST_NORMAL;
          end
        end
        ST_LOWER: begin
          state_d = ST_LOWER;
          if (rel_lo) begin
            ev = 1'b1; kind = KIND_RELEASE_LOWER; state_d = ST_NORMAL;
          end
        end
        default: begin
          if (raise_up) begin
            ev = 1'b1; kind = KIND_RAISE_UPPER; state_d = ST_UPPER;
          end
          // lower wins when both cross
          if (raise_lo) begin
            ev = 1'b1; kind = KIND_RAISE_LOWER; state_d = ST_LOWER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      primed_q    <= 1'b0;
      state_q     <= ST_NORMAL;
      res_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (advance) begin
        res_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          primed_q <= 1'b1;
          state_q  <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_analog_q <= sample_i.sample_analog;
      s1_enum_q   <= sample_i.sample_enum;
      s1_force_q  <= sample_i.force_record;
    end
    if (advance && s1_valid_q) begin
      prev_analog_q <= s1_analog_q;
      prev_enum_q   <= s1_enum_q;
      res_state_q   <= state_d;
      res_event_q   <= ev;
      res_kind_q    <= kind;
      res_record_q  <= rec;
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.alarm_state_out = res_state_q;
  assign result_o.alarm_event     = res_event_q;
  assign result_o.event_kind      = res_kind_q;
  assign result_o.record_request  = res_record_q;

  // ---- assertions ----
  a_kind_zero_without_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.alarm_event) |-> (result_o.event_kind == KIND_RAISE_UPPER))
    else $error("event_kind nonzero without alarm event");

  a_release_to_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.alarm_event &&
     (result_o.event_kind == KIND_RELEASE_UPPER || result_o.event_kind == KIND_RELEASE_LOWER))
    |-> (result_o.alarm_state_out == ST_NORMAL))
    else $error("release event left state not normal");

  a_first_sample_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && !primed_q)
    |=> (res_valid_q && res_record_q && !res_event_q && res_state_q == ST_NORMAL))
    else $error("first sample did not prime cleanly");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (s1_valid_q && res_valid_q && !result_o.ready))
    else $error("input stalled with room in the pipeline");

endmodule
